>>> src/cpd_pkg.sv
// Shared types and constants of the command packet deframer.
// Used by the front end, the command queue, the output stage and the top level.
package cpd_pkg;

  localparam int HDR_SIZE          = 6;
  localparam int MAX_PAYLOAD_BYTES = 512;
  localparam int HDR_W             = HDR_SIZE * 8;
  localparam int HCNT_W            = 3;
  localparam int LEN_W             = 10;
  localparam int CFG_W             = 11;
  localparam int QUEUE_DEPTH       = 8;
  localparam int QUEUE_AW          = $clog2(QUEUE_DEPTH);

  localparam logic [31:0] SYNC_MARKER = 32'hAAAA_AAAA;

  localparam logic CFG_COMMAND_ID  = 1'b0;
  localparam logic CFG_MAX_PAYLOAD = 1'b1;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  typedef struct packed {
    logic             is_header;
    logic             last;
    logic [HDR_W-1:0] data;
  } q_entry_t;

endpackage

>>> src/cpd_front.sv
// Front end: sync hunt, header collection and check, payload classification.
// Pushes one queue entry per forwarded header or payload byte; uses cpd_pkg.
module cpd_front import cpd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  input  logic [7:0]       in_byte,
  output logic             in_ready,
  input  logic             q_full,
  output logic             q_push,
  output q_entry_t         q_entry
);

  logic [10:0]       command_id;
  logic [10:0]       max_payload;
  phase_t            phase, phase_next;
  logic [31:0]       sync_shift;
  logic [7:0]        header_store [HDR_SIZE];
  logic [HCNT_W-1:0] header_count;
  logic [LEN_W-1:0]  payload_count;
  logic [LEN_W-1:0]  payload_length;

  logic              in_fire;
  logic [31:0]       sync_cat;
  logic              sync_hit;
  logic              hdr_wr;
  logic [HCNT_W-1:0] hcnt_inc;
  logic              hdr_done;
  logic [7:0]        hdr_view [HDR_SIZE];
  logic [10:0]       hdr_id;
  logic [15:0]       hdr_len;
  logic              hdr_ok;
  logic [LEN_W-1:0]  pcnt_inc;
  logic              pay_end;
  logic [HDR_W-1:0]  hdr_flat;

  assign in_ready = !q_full;
  assign in_fire  = in_valid && in_ready;

  assign sync_cat = {sync_shift[23:0], in_byte};
  assign sync_hit = (sync_cat == SYNC_MARKER);

  assign hdr_wr   = (header_count < HCNT_W'(HDR_SIZE));
  assign hcnt_inc = hdr_wr ? header_count + HCNT_W'(1) : header_count;
  assign hdr_done = (hcnt_inc >= HCNT_W'(HDR_SIZE));

  always_comb begin
    for (int i = 0; i < HDR_SIZE; i++) begin
      hdr_view[i] = (hdr_wr && header_count == HCNT_W'(i)) ? in_byte : header_store[i];
      hdr_flat[i*8 +: 8] = hdr_view[i];
    end
  end

  assign hdr_id  = {hdr_view[0][2:0], hdr_view[1]};
  assign hdr_len = {hdr_view[4], hdr_view[5]};
  assign hdr_ok  = (hdr_len != 16'd0) && (hdr_len <= {5'd0, max_payload})
                && (hdr_len <= 16'(MAX_PAYLOAD_BYTES)) && (hdr_id == command_id);

  assign pcnt_inc = payload_count + LEN_W'(1);
  assign pay_end  = (pcnt_inc >= payload_length);

  always_comb begin
    phase_next = phase;
    if (in_fire) begin
      unique case (phase)
        PH_HUNT:    if (sync_hit) phase_next = PH_HEADER;
        PH_HEADER:  if (hdr_done) phase_next = hdr_ok ? PH_PAYLOAD : PH_HUNT;
        PH_PAYLOAD: if (pay_end) phase_next = PH_HUNT;
        default:    phase_next = PH_HUNT;
      endcase
    end
  end

  always_comb begin
    q_push  = 1'b0;
    q_entry = '0;
    unique case (phase)
      PH_HEADER: begin
        q_push            = in_fire && hdr_done && hdr_ok;
        q_entry.is_header = 1'b1;
        q_entry.data      = hdr_flat;
      end
      PH_PAYLOAD: begin
        q_push       = in_fire;
        q_entry.last = pay_end;
        q_entry.data = HDR_W'(in_byte);
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      command_id  <= '0;
      max_payload <= 11'(MAX_PAYLOAD_BYTES);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COMMAND_ID:  command_id  <= cfg_data[10:0];
        CFG_MAX_PAYLOAD: max_payload <= {1'b0, cfg_data[9:0]};
        default:         command_id  <= command_id;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      sync_shift     <= '0;
      header_count   <= '0;
      payload_count  <= '0;
      payload_length <= '0;
    end else if (in_fire) begin
      phase <= phase_next;
      unique case (phase)
        PH_HUNT: begin
          sync_shift <= sync_hit ? 32'd0 : sync_cat;
          if (sync_hit) header_count <= '0;
        end
        PH_HEADER: begin
          header_count <= hdr_done ? '0 : hcnt_inc;
          if (hdr_done && hdr_ok) begin
            payload_length <= hdr_len[LEN_W-1:0];
            payload_count  <= '0;
          end
        end
        PH_PAYLOAD: begin
          payload_count <= pay_end ? '0 : pcnt_inc;
          if (pay_end) payload_length <= '0;
        end
        default: begin
          sync_shift <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && phase == PH_HEADER && hdr_wr) begin
      for (int i = 0; i < HDR_SIZE; i++) begin
        if (header_count == HCNT_W'(i)) header_store[i] <= in_byte;
      end
    end
  end

endmodule

>>> src/cpd_queue.sv
// Command queue between front end and output stage.
// Small first-word-fall-through queue of q_entry_t; uses cpd_pkg.
module cpd_queue import cpd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  q_entry_t push_entry,
  output logic     full,
  input  logic     pop,
  output logic     empty,
  output q_entry_t head
);

  q_entry_t            slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;
  logic                do_push;
  logic                do_pop;

  assign full    = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + QUEUE_AW'(1);
      if (do_pop) rd_ptr <= rd_ptr + QUEUE_AW'(1);
      priority if (do_push && !do_pop) count <= count + (QUEUE_AW+1)'(1);
      else if (do_pop && !do_push) count <= count - (QUEUE_AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_entry;
  end

endmodule

>>> src/cpd_back.sv
// Output stage: expands header entries into six beats, passes payload beats.
// Registered output toward the stream master; uses cpd_pkg.
module cpd_back import cpd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  q_entry_t   q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_header,
  output logic       out_last
);

  logic [HCNT_W-1:0] hdr_idx;
  logic              can_load;
  logic              load;
  logic              hdr_final;
  logic [7:0]        sel_byte;

  assign can_load  = !out_valid || out_ready;
  assign load      = can_load && !q_empty;
  assign hdr_final = (hdr_idx == HCNT_W'(HDR_SIZE - 1));
  assign q_pop     = load && (!q_head.is_header || hdr_final);

  always_comb begin
    sel_byte = q_head.data[7:0];
    if (q_head.is_header) begin
      for (int i = 0; i < HDR_SIZE; i++) begin
        if (hdr_idx == HCNT_W'(i)) sel_byte = q_head.data[i*8 +: 8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      hdr_idx   <= '0;
    end else begin
      if (can_load) out_valid <= !q_empty;
      if (load && q_head.is_header) hdr_idx <= hdr_final ? '0 : hdr_idx + HCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte   <= sel_byte;
      out_header <= q_head.is_header;
      out_last   <= q_head.last;
    end
  end

endmodule

>>> src/command_packet_deframer_core.sv
// Top level of the command packet deframer.
// Instantiates cpd_front, cpd_queue and cpd_back; uses cpd_pkg.
//
// Usage:
//   s_* channel: one received byte per beat in s_tdata.
//   m_* channel: forwarded bytes of accepted packets. m_tuser marks the six
//     header bytes, m_tlast marks the final payload byte.
//   cfg_we/cfg_index/cfg_data: index 0 is command_id, index 1 is max_payload.
//     Write only while the block is idle.
// The front end hunts for the 0xAAAAAAAA marker, collects the six header bytes
// and checks id and length. An accepted header enters the queue as one entry
// that the output stage expands into six beats; each payload byte is one entry.
// Throughput: one input byte per cycle while the eight-entry queue has room.
// The six-beat header burst backs the queue up by five entries, which the
// sync and header bytes of the next packet (ten beats, one entry) drain again.
// With the queue empty, an accepted payload byte is written into a queue slot and
// then loaded into the output register that raises m_tvalid; header beats follow the sixth header byte.
// Reset: phase goes to hunt, shift register and counters clear, queue empties,
//   command_id resets to 0 and max_payload to 512.
// Receiver stall: the output register holds; the queue fills, then s_tready drops.
module command_packet_deframer_core import cpd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,   // [7:0] rx_byte
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,   // [7:0] out_byte
  output logic             m_tuser,   // [0] is_header
  output logic             m_tlast
);

  logic     q_full;
  logic     q_push;
  q_entry_t q_in;
  logic     q_pop;
  logic     q_empty;
  q_entry_t q_head;

  cpd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_tvalid),
    .in_byte   (s_tdata),
    .in_ready  (s_tready),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_in)
  );

  cpd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .empty      (q_empty),
    .head       (q_head)
  );

  cpd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_byte   (m_tdata),
    .out_header (m_tuser),
    .out_last   (m_tlast)
  );

endmodule

>>> tb/command_packet_deframer_core_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for command_packet_deframer_core: drives received bytes,
// tracks sync hunt, header decode and payload forwarding, and checks each output beat.
// Depends on cpd_pkg and the command_packet_deframer_core RTL.
module command_packet_deframer_core_test;
  import cpd_pkg::*;

  localparam int CYCLE_LIMIT = 300000;

  typedef struct packed {
    logic [7:0] data;
    logic       is_header;
    logic       last;
  } beat_t;

  class deframe_tracker;
    logic [10:0] command_id;
    logic [10:0] max_payload;
    logic [31:0] sync_shift;
    phase_t      phase;
    logic [7:0]  header_store [HDR_SIZE];
    logic [2:0]  header_count;
    logic [9:0]  payload_count;
    logic [9:0]  payload_length;
    beat_t       pending_beats [$];
    int          mismatches;

    function new();
      command_id     = '0;
      max_payload    = 11'd512;
      sync_shift     = '0;
      phase          = PH_HUNT;
      header_count   = '0;
      payload_count  = '0;
      payload_length = '0;
      mismatches     = 0;
    endfunction

    function void configure(logic idx, logic [CFG_W-1:0] value);
      if (idx == CFG_COMMAND_ID) command_id = value[10:0];
      else max_payload = {1'b0, value[9:0]};
    endfunction

    function int pending();
      return pending_beats.size();
    endfunction

    function void push_beat(logic [7:0] data, logic is_header, logic last);
      beat_t b;
      b.data      = data;
      b.is_header = is_header;
      b.last      = last;
      pending_beats.push_back(b);
    endfunction

    function void take_byte(logic [7:0] rx);
      logic [10:0] id;
      logic [15:0] len;
      case (phase)
        PH_HUNT: begin
          sync_shift = {sync_shift[23:0], rx};
          if (sync_shift == SYNC_MARKER) begin
            sync_shift   = '0;
            header_count = '0;
            phase        = PH_HEADER;
          end
        end
        PH_HEADER: begin
          if (header_count < HDR_SIZE) begin
            header_store[header_count] = rx;
            header_count++;
          end
          if (header_count >= HDR_SIZE) begin
            id  = {header_store[0][2:0], header_store[1]};
            len = {header_store[4], header_store[5]};
            if (len >= 1 && len <= max_payload && len <= MAX_PAYLOAD_BYTES
                && id == command_id) begin
              payload_length = len[9:0];
              payload_count  = '0;
              phase          = PH_PAYLOAD;
              for (int i = 0; i < HDR_SIZE; i++)
                push_beat(header_store[i], 1'b1, 1'b0);
            end else begin
              phase = PH_HUNT;
            end
            header_count = '0;
          end
        end
        PH_PAYLOAD: begin
          payload_count = payload_count + 10'd1;
          if (payload_count >= payload_length) begin
            push_beat(rx, 1'b0, 1'b1);
            phase          = PH_HUNT;
            payload_count  = '0;
            payload_length = '0;
          end else begin
            push_beat(rx, 1'b0, 1'b0);
          end
        end
        default: begin
          phase      = PH_HUNT;
          sync_shift = '0;
        end
      endcase
    endfunction

    function void match_beat(logic [7:0] data, logic is_header, logic last);
      beat_t want;
      if (pending_beats.size() == 0) begin
        $display("%0t: unexpected beat data=%h is_header=%b last=%b",
                 $time, data, is_header, last);
        mismatches++;
        return;
      end
      want = pending_beats.pop_front();
      if (data !== want.data) begin
        $display("%0t: data expected %h actual %h", $time, want.data, data);
        mismatches++;
      end
      if (is_header !== want.is_header) begin
        $display("%0t: is_header expected %b actual %b", $time, want.is_header, is_header);
        mismatches++;
      end
      if (last !== want.last) begin
        $display("%0t: last expected %b actual %b", $time, want.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic             cfg_index = CFG_COMMAND_ID;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [7:0]       s_tdata = '0;   // [7:0] rx_byte
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [7:0]       m_tdata;        // [7:0] out_byte
  logic             m_tuser;        // [0] is_header
  logic             m_tlast;

  deframe_tracker tracker;
  bit             quiet = 1'b0;
  bit             rx_hold_req = 1'b0;
  int             bytes_sent = 0;
  int             cycle_count = 0;

  command_packet_deframer_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : receiver
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) tracker.match_beat(m_tdata, m_tuser, m_tlast);
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        stall_left  = 99;
        m_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 8);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] value);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tracker.take_byte(value);
    bytes_sent++;
  endtask

  // drain: hold the input, wait for every pending beat, then let the pipe settle
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.configure(idx, value);
  endtask

  task automatic send_frame(input logic [10:0] id, input logic [15:0] len, input int body);
    logic [4:0] top;
    top = 5'($urandom);
    repeat (4) send_byte(SYNC_MARKER[7:0]);
    send_byte({top, id[10:8]});
    send_byte(id[7:0]);
    send_byte(8'($urandom));
    send_byte(8'($urandom));
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    repeat (body) send_byte(($urandom_range(0, 4) == 0) ? SYNC_MARKER[7:0] : 8'($urandom));
  endtask

  task automatic random_packet();
    int          pick;
    int          cap;
    logic [10:0] id;
    logic [15:0] len;
    logic [7:0]  breaker;
    bit          ok;
    repeat ($urandom_range(0, 2)) send_byte(8'($urandom));
    pick = $urandom_range(0, 19);
    if (pick == 5) begin
      // broken marker: three sync bytes then something else
      breaker = 8'($urandom_range(0, 254));
      if (breaker >= SYNC_MARKER[7:0]) breaker++;
      repeat (3) send_byte(SYNC_MARKER[7:0]);
      send_byte(breaker);
      return;
    end
    cap = (tracker.max_payload < 12) ? tracker.max_payload : 12;
    id  = tracker.command_id;
    len = 16'($urandom_range(1, cap));
    if (pick == 0) id = id ^ (11'd1 << $urandom_range(0, 10));
    if (pick == 1) len = '0;
    else if (pick == 2) len = 16'(tracker.max_payload + $urandom_range(1, 600));
    else if (pick == 3) len = 16'($urandom);
    else if (pick == 4 && tracker.max_payload <= 40) len = 16'(tracker.max_payload);
    ok = (id == tracker.command_id) && len >= 1 && len <= tracker.max_payload
         && len <= MAX_PAYLOAD_BYTES;
    send_frame(id, len, ok ? int'(len) : int'($urandom_range(0, 3)));
  endtask

  initial begin : stimulus
    tracker = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: tightest settings, extreme bytes, sync inside payload, too-long header
    write_reg(CFG_COMMAND_ID, 11'h7FF);
    write_reg(CFG_MAX_PAYLOAD, 11'd1);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(11'h7FF, 16'd1, 0);
    send_byte(SYNC_MARKER[7:0]);
    send_frame(11'h7FF, 16'd2, 0);
    wait_idle();

    write_reg(CFG_COMMAND_ID, 11'h000);
    write_reg(CFG_MAX_PAYLOAD, 11'd511);
    rx_hold_req = 1'b1;
    send_frame(11'h000, 16'd513, 2);
    bytes_sent = 0;
    while (bytes_sent < 140) random_packet();
    wait_idle();

    write_reg(CFG_COMMAND_ID, CFG_W'($urandom_range(1, 2046)));
    write_reg(CFG_MAX_PAYLOAD, CFG_W'($urandom_range(1, 40)));
    while (bytes_sent < 210) random_packet();
    wait_idle();
    while (bytes_sent < 280) random_packet();
    wait_idle();

    write_reg(CFG_COMMAND_ID, CFG_W'($urandom_range(0, 2047)));
    write_reg(CFG_MAX_PAYLOAD, CFG_W'($urandom_range(1, 512)));
    quiet = 1'b1;
    while (bytes_sent < 400) random_packet();
    wait_idle();

    if (tracker.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
